// ===== rtl/core/keyboard_report_slot_tracker_defines.svh =====
// Assertion macros shared by the keyboard report slot tracker RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef KEYBOARD_REPORT_SLOT_TRACKER_DEFINES_SVH
`define KEYBOARD_REPORT_SLOT_TRACKER_DEFINES_SVH

`ifndef ASSERT_OFF
// expr must hold at every clock edge out of reset
`define KRST_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");
// ante implies cons in the same cycle
`define KRST_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// ante implies cons in the next cycle
`define KRST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define KRST_ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define KRST_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define KRST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/krst_pkg.sv =====
// Types and constants of the keyboard report slot tracker.
// No dependencies; imported by krst_eval and the top level.
package krst_pkg;

	localparam int KEY_SLOTS = 6;
	localparam int KEY_W     = 8;
	localparam int MOD_W     = 8;
	localparam int OQ_DEPTH  = 4;
	localparam int OQ_PTR_W  = 2;
	localparam int OQ_CNT_W  = 3;

	localparam logic [KEY_W-1:0] EMPTY_KEY = 8'h00;

	// configuration register indexes
	localparam logic CFG_LOW_BOUND  = 1'b0;
	localparam logic CFG_HIGH_BOUND = 1'b1;

	typedef logic [KEY_SLOTS-1:0][KEY_W-1:0] key_set_t;

	typedef struct packed {
		logic             last;
		key_set_t         slots;
		logic [MOD_W-1:0] mods;
	} report_t;

	// reports produced by one scan, rpt0 goes out first
	typedef struct packed {
		logic [1:0] count;
		report_t    rpt0;
		report_t    rpt1;
	} eval_t;

endpackage

// ===== rtl/core/krst_eval.sv =====
// Combinational update of the sent report for one scanned report.
// Depends on krst_pkg.
module krst_eval (
	input  logic [7:0]        mods,
	input  krst_pkg::key_set_t keys,
	input  logic [7:0]        sent_mods,
	input  krst_pkg::key_set_t sent_slots,
	input  logic [7:0]        low_bound,
	input  logic [7:0]        high_bound,
	output logic [7:0]        next_mods,
	output krst_pkg::key_set_t next_slots,
	output krst_pkg::eval_t    res
);
	import krst_pkg::*;

	logic     match;
	logic     shortcut;
	logic     released;
	logic     pressed;
	logic     hit;
	logic     placed;
	key_set_t slots_r;
	key_set_t slots_p;
	report_t  rpt_rel;
	report_t  rpt_prs;
	report_t  rpt_mod;

	always_comb begin
		match = (mods == sent_mods);
		for (int i = 0; i < KEY_SLOTS; i++) begin
			logic in_sent;
			logic in_keys;
			in_sent = 1'b0;
			in_keys = 1'b0;
			for (int j = 0; j < KEY_SLOTS; j++) begin
				in_sent = in_sent | (sent_slots[j] == keys[i]);
				in_keys = in_keys | (keys[j] == sent_slots[i]);
			end
			match = match & in_sent & in_keys;
		end
	end

	assign shortcut = (keys[0] > low_bound) && (keys[0] < high_bound);

	// release: clear sent slots no longer held
	always_comb begin
		released = 1'b0;
		for (int i = 0; i < KEY_SLOTS; i++) begin
			logic held;
			held = 1'b0;
			for (int j = 0; j < KEY_SLOTS; j++) begin
				held = held | (keys[j] == sent_slots[i]);
			end
			slots_r[i] = held ? sent_slots[i] : EMPTY_KEY;
			released   = released | ~held;
		end
	end

	// press: six dependent insertions, each into the lowest empty slot
	always_comb begin
		slots_p = slots_r;
		pressed = 1'b0;
		hit     = 1'b0;
		placed  = 1'b0;
		for (int i = 0; i < KEY_SLOTS; i++) begin
			hit = 1'b0;
			for (int j = 0; j < KEY_SLOTS; j++) begin
				hit = hit | (slots_p[j] == keys[i]);
			end
			if (!hit) begin
				pressed = 1'b1;
				placed  = 1'b0;
				for (int k = 0; k < KEY_SLOTS; k++) begin
					if (!placed && slots_p[k] == EMPTY_KEY) begin
						slots_p[k] = keys[i];
						placed     = 1'b1;
					end
				end
			end
		end
	end

	always_comb begin
		rpt_rel = '{last: !pressed, slots: slots_r, mods: sent_mods};
		rpt_prs = '{last: 1'b1, slots: slots_p, mods: sent_mods};
		rpt_mod = '{last: 1'b1, slots: sent_slots, mods: mods};
		res       = '0;
		next_mods  = sent_mods;
		next_slots = sent_slots;
		if (!match && !shortcut) begin
			next_slots = slots_p;
			priority if (released && pressed) begin
				res = '{count: 2'd2, rpt0: rpt_rel, rpt1: rpt_prs};
			end else if (released) begin
				res = '{count: 2'd1, rpt0: rpt_rel, rpt1: rpt_rel};
			end else if (pressed) begin
				res = '{count: 2'd1, rpt0: rpt_prs, rpt1: rpt_prs};
			end else begin
				next_mods = mods;
				res = '{count: 2'd1, rpt0: rpt_mod, rpt1: rpt_mod};
			end
		end
	end

endmodule

// ===== rtl/core/keyboard_report_slot_tracker.sv =====
// Keyboard report slot tracker: input register, report update, output queue.
// Depends on krst_pkg, krst_eval and keyboard_report_slot_tracker_defines.svh.
//
// Usage:
//   s_* carries one scanned report per word; m_* carries reports to send,
//   with m_tlast set on the final report a scan causes. A scan causes zero,
//   one or two reports. cfg_we/cfg_addr/cfg_wdata write the shortcut bounds
//   (index 0 low, index 1 high, both exclusive); write only while idle.
//   An accepted scan is held in the input register, evaluated there, and
//   its reports are written to the report queue that drives m_*.
//   Throughput: one scan per cycle while the receiver takes reports and
//   each scan causes at most one report; scans causing two are limited by
//   the single output port of the four-word report queue.
//   Reset clears the sent report, the bounds and the queue.
//   When the receiver stalls the queue fills; a scan waits in the input
//   register until the queue has room for two words, with s_tready low.
module keyboard_report_slot_tracker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// new_modifiers, new_key_a .. new_key_f
	input  logic [55:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// out_modifiers, out_slot_a .. out_slot_f
	output logic [55:0] m_tdata,
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [7:0]  cfg_wdata
);
	import krst_pkg::*;

	`include "keyboard_report_slot_tracker_defines.svh"

	logic                valid_s1;
	logic [55:0]         data_s1;
	logic [7:0]          low_bound_q;
	logic [7:0]          high_bound_q;
	logic [7:0]          sent_mods_q;
	key_set_t            sent_slots_q;
	logic [7:0]          next_mods;
	key_set_t            next_slots;
	eval_t               res;
	logic                proc;
	logic                pop;
	report_t             oq_mem [OQ_DEPTH];
	logic [OQ_PTR_W-1:0] wr_ptr_q;
	logic [OQ_PTR_W-1:0] rd_ptr_q;
	logic [OQ_CNT_W-1:0] fill_q;
	report_t             head;

	// evaluate only when the queue can take two words
	assign proc     = valid_s1 && (fill_q <= OQ_CNT_W'(OQ_DEPTH - 2));
	assign s_tready = !valid_s1 || proc;
	assign pop      = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			data_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_bound_q  <= '0;
			high_bound_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_LOW_BOUND:  low_bound_q  <= cfg_wdata;
				CFG_HIGH_BOUND: high_bound_q <= cfg_wdata;
				default:        low_bound_q  <= low_bound_q;
			endcase
		end
	end

	krst_eval u_eval (
		.mods       (data_s1[7:0]),
		.keys       (data_s1[55:8]),
		.sent_mods  (sent_mods_q),
		.sent_slots (sent_slots_q),
		.low_bound  (low_bound_q),
		.high_bound (high_bound_q),
		.next_mods  (next_mods),
		.next_slots (next_slots),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sent_mods_q  <= '0;
			sent_slots_q <= '0;
		end else if (proc) begin
			sent_mods_q  <= next_mods;
			sent_slots_q <= next_slots;
		end
	end

	// report queue
	always_ff @(posedge clk) begin
		if (proc && res.count != 2'd0) begin
			oq_mem[wr_ptr_q] <= res.rpt0;
		end
		if (proc && res.count == 2'd2) begin
			oq_mem[wr_ptr_q + 1'b1] <= res.rpt1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (proc) begin
				wr_ptr_q <= wr_ptr_q + OQ_PTR_W'(res.count);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			fill_q <= fill_q + (proc ? OQ_CNT_W'(res.count) : '0) - OQ_CNT_W'(pop);
		end
	end

	assign head     = oq_mem[rd_ptr_q];
	assign m_tvalid = (fill_q != '0);
	assign m_tdata  = {head.slots, head.mods};
	assign m_tlast  = head.last;

	`KRST_ASSERT_ALWAYS(a_fill_bound, clk, arst_n, fill_q <= OQ_CNT_W'(OQ_DEPTH))
	`KRST_ASSERT_IMPL(a_newest_is_last, clk, arst_n, fill_q != '0,
		oq_mem[wr_ptr_q - 1'b1].last)
	`KRST_ASSERT_NEXT(a_silent_keeps_state, clk, arst_n, proc && res.count == 2'd0,
		$stable(sent_slots_q) && $stable(sent_mods_q))
	`KRST_ASSERT_IMPL(a_ptr_gap, clk, arst_n, fill_q < OQ_CNT_W'(OQ_DEPTH),
		OQ_CNT_W'(OQ_PTR_W'(wr_ptr_q - rd_ptr_q)) == fill_q)

endmodule
